/* rtl/prcdd_pkg.sv */
// Package for the polygon ray-cast delta decoder.
// Holds parser phase codes, marker bytes, coordinate widths and query register indices; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prcdd_pkg;
    localparam int COORD_W = 32;
    localparam int QUERY_W = 25;
    localparam logic [7:0] MARK_WORD16 = 8'h80;
    localparam logic [7:0] MARK_WORD32 = 8'h7F;
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_MARK  = 3'd2;
    localparam logic [2:0] PH_D16   = 3'd3;
    localparam logic [2:0] PH_D32   = 3'd4;
    localparam logic [2:0] PH_IDLE  = 3'd5;
    localparam logic [0:0] REG_QLAT = 1'b0;
    localparam logic [0:0] REG_QLON = 1'b1;
endpackage
`default_nettype wire

/* rtl/polygon_ray_cast_delta_decoder.sv */
// Polygon ray-cast delta decoder: one record byte per item, one parity result per record.
// A result is valid in the cycle after a zero-count byte, or once the last edge-closing byte
// has passed multiply, load and 64 steps of a restoring divide, finish (multiply, finish alone
// for a non-candidate edge). Throughput: one byte per cycle; an edge-closing byte blocks input
// until its finish step is done, and a waiting result blocks input until it is taken.
// Reset (rst_n, asynchronous, low): parser awaits a start point, query point is zero.
`timescale 1ns / 1ps
`default_nettype none
module polygon_ray_cast_delta_decoder
    import prcdd_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [24:0] cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // start_record
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] inside_res, [32:1] edges_checked, zero fill
);
    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_MUL  = 2'd1;
    localparam logic [1:0] SQ_DIV  = 2'd2;
    localparam logic [1:0] SQ_FIN  = 2'd3;

    logic signed [24:0] qlat_reg, qlon_reg;
    logic [2:0]  phase_reg;
    logic [31:0] asm_reg;
    logic [31:0] plat_reg, plon_reg, clat_reg, clon_reg;
    logic [31:0] left_reg, done_reg;
    logic        islon_reg, par_reg;
    logic [1:0]  sq_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] quo_reg;     // dividend shifted into quotient
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;     // |dlat|
    logic        qneg_reg, cand_reg, fin_done_reg;
    logic        ov_reg;
    logic [31:0] ocnt_reg;
    logic        opar_reg;

    assign s_axis_tready = (sq_reg == SQ_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {7'd0, ocnt_reg, opar_reg};

    wire acc = s_axis_tvalid && s_axis_tready;
    wire [31:0] qlat32 = {{7{qlat_reg[24]}}, qlat_reg};
    wire [31:0] qlon32 = {{7{qlon_reg[24]}}, qlon_reg};

    // byte-level decode
    logic [2:0]  ph;
    logic [2:0]  bi3;
    logic [31:0] aw, d, nclat, nclon, nplat, nplon;
    logic        have_d, rec_done;
    logic [2:0]  ph_n;
    logic [2:0]  bi_n;
    logic [31:0] left_n;
    logic        idx8;
    logic [2:0]  sidx_reg;
    logic [2:0]  sidx_n;
    always_comb
    begin
        ph = s_axis_tuser ? PH_START : phase_reg;
        bi3 = s_axis_tuser ? 3'd0 : sidx_reg;
        aw = s_axis_tuser ? 32'd0 : asm_reg;
        nclat = s_axis_tuser ? 32'd0 : clat_reg;
        nclon = s_axis_tuser ? 32'd0 : clon_reg;
        nplat = s_axis_tuser ? 32'd0 : plat_reg;
        nplon = s_axis_tuser ? 32'd0 : plon_reg;
        left_n = s_axis_tuser ? 32'd0 : left_reg;
        d = 32'd0;
        have_d = 1'b0;
        rec_done = 1'b0;
        ph_n = ph;
        sidx_n = bi3;
        idx8 = 1'b0;
        case (ph)
            PH_START:
            begin
                aw = aw | ({24'd0, s_axis_tdata} << {bi3[1:0], 3'd0});
                if (bi3 == 3'd3)
                begin
                    nclat = aw;
                    aw = 32'd0;
                end
                if (bi3 == 3'd7)
                begin
                    nclon = aw;
                    nplat = nclat;
                    nplon = aw;
                    aw = 32'd0;
                    sidx_n = 3'd0;
                    ph_n = PH_COUNT;
                end
                else
                    sidx_n = bi3 + 3'd1;
            end
            PH_COUNT:
            begin
                aw = aw | ({24'd0, s_axis_tdata} << {bi3[1:0], 3'd0});
                if (bi3 == 3'd3)
                begin
                    left_n = aw;
                    aw = 32'd0;
                    sidx_n = 3'd0;
                    if (aw == 32'd0 && left_n == 32'd0)
                        rec_done = 1'b1;
                    else
                        ph_n = PH_MARK;
                end
                else
                    sidx_n = bi3 + 3'd1;
            end
            PH_MARK:
            begin
                aw = 32'd0;
                sidx_n = 3'd0;
                if (s_axis_tdata == MARK_WORD16)
                    ph_n = PH_D16;
                else if (s_axis_tdata == MARK_WORD32)
                    ph_n = PH_D32;
                else
                begin
                    d = {{24{s_axis_tdata[7]}}, s_axis_tdata};
                    have_d = 1'b1;
                end
            end
            PH_D16:
            begin
                aw = aw | ({24'd0, s_axis_tdata} << {bi3[0], 3'd0});
                if (bi3 != 3'd0)
                begin
                    d = {{16{aw[15]}}, aw[15:0]};
                    have_d = 1'b1;
                    aw = 32'd0;
                    sidx_n = 3'd0;
                    ph_n = PH_MARK;
                end
                else
                    sidx_n = bi3 + 3'd1;
            end
            PH_D32:
            begin
                aw = aw | ({24'd0, s_axis_tdata} << {bi3[1:0], 3'd0});
                if (bi3 == 3'd3)
                begin
                    d = aw;
                    have_d = 1'b1;
                    aw = 32'd0;
                    sidx_n = 3'd0;
                    ph_n = PH_MARK;
                end
                else
                    sidx_n = bi3 + 3'd1;
            end
            default: ;
        endcase
        idx8 = have_d && (s_axis_tuser ? 1'b0 : islon_reg);
        bi_n = sidx_n;
    end

    // edge candidate test on new vertex
    wire [31:0] elat = nclat;
    wire [31:0] elon = nclon + d;
    wire signed [31:0] salat = $signed(nplat), sblat = $signed(elat);
    wire signed [31:0] salon = $signed(nplon), sblon = $signed(elon);
    wire signed [31:0] sq = $signed(qlat32), sqn = $signed(qlon32);
    wire signed [31:0] lo = (salat < sblat) ? salat : sblat;
    wire signed [31:0] hi = (salat < sblat) ? sblat : salat;
    wire signed [31:0] lmx = (salon < sblon) ? sblon : salon;
    wire cand = (sq > lo) && (sq <= hi) && (sqn <= lmx) && (nplat != elat);
    wire [31:0] dq_w = qlat32 - nplat;
    wire [31:0] dlon_w = elon - nplon;
    wire [31:0] dlat_w = elat - nplat;

    // shared datapath: product then restoring division
    logic signed [63:0] prod_reg;
    logic signed [31:0] dq_reg, dlon_reg, dlat_reg;
    wire [63:0] pabs = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
    wire [32:0] rsh = {rem_reg, quo_reg[63]};
    wire        ge = rsh >= {1'b0, dvs_reg};
    wire [63:0] qs = qneg_reg ? (64'd0 - quo_reg) : quo_reg;
    wire signed [63:0] xv = $signed(qs) + $signed({{32{plon_reg[31]}}, plon_reg});
    wire signed [63:0] qlon64 = {{32{qlon32[31]}}, qlon32};
    wire        hit = cand_reg && (qlon64 <= xv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlat_reg <= '0; qlon_reg <= '0;
            phase_reg <= PH_START; sidx_reg <= 3'd0; asm_reg <= '0;
            plat_reg <= '0; plon_reg <= '0; clat_reg <= '0; clon_reg <= '0;
            left_reg <= '0; done_reg <= '0; islon_reg <= 1'b0; par_reg <= 1'b0;
            sq_reg <= SQ_IDLE; cnt_reg <= '0; ov_reg <= 1'b0;
            fin_done_reg <= 1'b0; cand_reg <= 1'b0; qneg_reg <= 1'b0;
            quo_reg <= '0; rem_reg <= '0; dvs_reg <= '0; prod_reg <= '0;
            dq_reg <= '0; dlon_reg <= '0; dlat_reg <= '0;
            ocnt_reg <= '0; opar_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_QLAT) qlat_reg <= $signed(cfg_data);
                else qlon_reg <= $signed(cfg_data);
            end
            if (acc)
            begin
                phase_reg <= rec_done ? PH_IDLE : ph_n;
                sidx_reg <= bi_n; asm_reg <= aw;
                clat_reg <= (have_d && !idx8) ? (nclat + d) : nclat;
                clon_reg <= idx8 ? elon : nclon;
                plat_reg <= nplat; plon_reg <= nplon;
                left_reg <= left_n;
                if (s_axis_tuser)
                begin
                    done_reg <= '0; par_reg <= 1'b0;
                end
                if (have_d)
                    islon_reg <= !idx8;
                else if (s_axis_tuser)
                    islon_reg <= 1'b0;
                if (rec_done)
                begin
                    ov_reg <= 1'b1; opar_reg <= 1'b0; ocnt_reg <= 32'd0;
                end
                if (idx8)
                begin
                    // close an edge: start the arithmetic sequence
                    dq_reg <= $signed(dq_w); dlon_reg <= $signed(dlon_w);
                    dlat_reg <= $signed(dlat_w);
                    cand_reg <= cand;
                    fin_done_reg <= (left_n == 32'd1);
                    sq_reg <= SQ_MUL;
                end
            end
            else
            begin
                if (m_axis_tvalid && m_axis_tready)
                    ov_reg <= 1'b0;
                case (sq_reg)
                    SQ_MUL:
                    begin
                        prod_reg <= dq_reg * dlon_reg;
                        dvs_reg <= dlat_reg[31] ? (32'd0 - dlat_reg) : dlat_reg;
                        cnt_reg <= 7'd0;
                        sq_reg <= cand_reg ? SQ_DIV : SQ_FIN;
                    end
                    SQ_DIV:
                    begin
                        // load on count zero, then one quotient bit per cycle
                        if (cnt_reg == 7'd0)
                        begin
                            quo_reg <= pabs;
                            rem_reg <= '0;
                            qneg_reg <= prod_reg[63] ^ dlat_reg[31];
                        end
                        else
                        begin
                            rem_reg <= ge ? (rsh[31:0] - dvs_reg) : rsh[31:0];
                            quo_reg <= {quo_reg[62:0], ge};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd64)
                            sq_reg <= SQ_FIN;
                    end
                    SQ_FIN:
                    begin
                        par_reg <= par_reg ^ hit;
                        plat_reg <= clat_reg; plon_reg <= clon_reg;
                        done_reg <= done_reg + 32'd1;
                        left_reg <= left_reg - 32'd1;
                        sq_reg <= SQ_IDLE;
                        if (fin_done_reg)
                        begin
                            phase_reg <= PH_IDLE;
                            ov_reg <= 1'b1;
                            opar_reg <= par_reg ^ hit;
                            ocnt_reg <= done_reg + 32'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_reg != SQ_IDLE) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("handshake open during arithmetic");
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_IDLE)
        else $error("illegal parser phase");
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tdata[39:33] == 7'd0)
        else $error("fill bits not zero");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'd65)
        else $error("divide step count out of range");
endmodule
`default_nettype wire
